[sv/haar2d_pkg.sv]
package haar2d_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 2048;
	localparam int unsigned HEIGHT_LIMIT  = 2048;
	localparam int unsigned PIXEL_BITS    = 8;
	localparam int unsigned DIM_BITS      = 12;
	localparam int unsigned DEF_WIDTH     = 512;
	localparam int unsigned DEF_HEIGHT    = 512;
	localparam int unsigned TDATA_BITS    = 40;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIXEL_BITS-1:0] pixel_t;

	// position of one beat inside the frame
	typedef struct packed {
		logic odd_row;
		logic odd_col;
		logic last;
	} pos_t;

	typedef struct packed {
		logic                       frame_end;
		logic signed [PIXEL_BITS+1:0] diag;
		logic signed [PIXEL_BITS:0]   vdetail;
		logic signed [PIXEL_BITS:0]   hdetail;
		logic [PIXEL_BITS-1:0]        approx;
	} coef_t;

endpackage

[sv/haar2d_raster.sv]
module haar2d_raster #(
	parameter int unsigned MAX_WIDTH = haar2d_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [0:0]                   cfg_index,
	input  logic [haar2d_pkg::DIM_BITS-1:0] cfg_data,
	input  logic                         step,
	output haar2d_pkg::pos_t             pos,
	output logic [$clog2(MAX_WIDTH)-1:0] addr
);
	import haar2d_pkg::*;

	localparam int unsigned AW    = $clog2(MAX_WIDTH);
	localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW    = $clog2(HEIGHT_LIMIT + 1);
	localparam int unsigned W_RST = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;

	logic [CW-1:0] w_q, w_d;
	logic [RW-1:0] h_q, h_d;
	logic [CW-1:0] col_q, col, col_inc;
	logic [RW-1:0] row_q, row_a, row, row_inc;
	logic          wrap_c, end_row;

	// clamp geometry once, at the register write
	always_comb begin
		if (cfg_data < DIM_BITS'(2)) begin
			w_d = CW'(2);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			w_d = CW'(MAX_WIDTH);
		end else begin
			w_d = CW'(cfg_data);
		end
		if (cfg_data < DIM_BITS'(2)) begin
			h_d = RW'(2);
		end else if (32'(cfg_data) > HEIGHT_LIMIT) begin
			h_d = RW'(HEIGHT_LIMIT);
		end else begin
			h_d = RW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= CW'(W_RST);
			h_q <= RW'(DEF_HEIGHT);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  w_q <= w_d;
				REG_IMAGE_HEIGHT: h_q <= h_d;
				default: ;
			endcase
		end
	end

	// counters left beyond a shrunken bound wrap before use
	always_comb begin
		wrap_c  = (col_q >= w_q);
		col     = wrap_c ? '0 : col_q;
		row_a   = row_q + RW'(wrap_c);
		row     = (row_a >= h_q) ? '0 : row_a;
		col_inc = col + CW'(1);
		row_inc = row + RW'(1);
		end_row = (col_inc >= w_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= end_row ? '0 : col_inc;
			if (end_row) begin
				row_q <= (row_inc >= h_q) ? '0 : row_inc;
			end else begin
				row_q <= row;
			end
		end
	end

	always_comb begin
		pos.odd_row = row[0];
		pos.odd_col = col[0];
		pos.last    = row[0] && col[0]
			&& (row[RW-1:1] == (RW-1)'(h_q[RW-1:1] - 1'b1))
			&& (col[CW-1:1] == (CW-1)'(w_q[CW-1:1] - 1'b1));
		addr = col[AW-1:0];
	end

endmodule

[sv/haar2d_line_store.sv]
module haar2d_line_store #(
	parameter int unsigned MAX_WIDTH = haar2d_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  haar2d_pkg::pos_t             pos,
	input  logic [$clog2(MAX_WIDTH)-1:0] addr,
	input  haar2d_pkg::pixel_t           px,
	input  logic                         adv,
	output logic                         valid_s1,
	output haar2d_pkg::pos_t             pos_s1,
	output haar2d_pkg::pixel_t           px_s1,
	output haar2d_pkg::pixel_t           rd_s1
);
	import haar2d_pkg::*;

	pixel_t mem [MAX_WIDTH];

	// even rows fill the store, odd rows read the pixel above
	always_ff @(posedge clk) begin
		if (load) begin
			if (!pos.odd_row) begin
				mem[addr] <= px;
			end else begin
				rd_s1  <= mem[addr];
				pos_s1 <= pos;
				px_s1  <= px;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load && pos.odd_row) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

[sv/haar2d_butterfly.sv]
module haar2d_butterfly (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  haar2d_pkg::pos_t   pos_s1,
	input  haar2d_pkg::pixel_t px_s1,
	input  haar2d_pkg::pixel_t rd_s1,
	input  logic               out_ready,
	output logic               adv,
	output logic               out_valid,
	output haar2d_pkg::coef_t  coef
);
	import haar2d_pkg::*;

	localparam int unsigned P = PIXEL_BITS;

	pixel_t                tl_q, bl_q;
	logic [P-1:0]          s0, s1;
	logic signed [P:0]     d0, d1;
	logic [P-1:0]          s0_s2, s1_s2;
	logic signed [P:0]     d0_s2, d1_s2;
	logic                  last_s2, valid_s2;
	logic                  out_v_q, en_out;
	coef_t                 coef_q;
	logic [P:0]            asum;
	logic signed [P+1:0]   hsum, hrnd;

	assign en_out = !out_v_q || out_ready;
	assign adv    = !valid_s2 || en_out;

	// left column of the block: pixel above and the left-bottom pixel
	always_ff @(posedge clk) begin
		if (valid_s1 && adv && !pos_s1.odd_col) begin
			tl_q <= rd_s1;
			bl_q <= px_s1;
		end
	end

	// column sums are non-negative, so the halving is a plain shift
	always_comb begin
		s0 = P'(({1'b0, tl_q} + {1'b0, bl_q}) >> 1);
		s1 = P'(({1'b0, rd_s1} + {1'b0, px_s1}) >> 1);
		d0 = $signed({1'b0, tl_q}) - $signed({1'b0, bl_q});
		d1 = $signed({1'b0, rd_s1}) - $signed({1'b0, px_s1});
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && pos_s1.odd_col) begin
			s0_s2   <= s0;
			s1_s2   <= s1;
			d0_s2   <= d0;
			d1_s2   <= d1;
			last_s2 <= pos_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && pos_s1.odd_col;
		end
	end

	// hdetail rounds toward zero: bias negative sums by one before the shift
	always_comb begin
		asum = {1'b0, s0_s2} + {1'b0, s1_s2};
		hsum = {d0_s2[P], d0_s2} + {d1_s2[P], d1_s2};
		hrnd = hsum + (P+2)'(hsum[P+1]);
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			coef_q.approx    <= asum[P:1];
			coef_q.hdetail   <= hrnd[P+1:1];
			coef_q.vdetail   <= $signed({1'b0, s0_s2}) - $signed({1'b0, s1_s2});
			coef_q.diag      <= {d0_s2[P], d0_s2} - {d1_s2[P], d1_s2};
			coef_q.frame_end <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= valid_s2;
		end
	end

	assign out_valid = out_v_q;
	assign coef      = coef_q;

endmodule

[sv/integer_haar_2d_forward.sv]
// One level of the forward 2-D integer Haar (S-) transform on a raster pixel stream.
//
// s_axis carries one 8-bit grey pixel per beat in raster order. m_axis carries one
// coefficient beat per 2x2 block, issued on the pixel at each odd row and odd column;
// tlast marks the last block of the frame. A trailing odd row or column gives nothing.
// The cfg channel writes image_width (index 0) and image_height (index 1); values are
// clamped to [2, MAX_WIDTH] and [2, 2048]. cfg_ready is always high; write only while
// the block is idle.
//
// Throughput: one pixel per clock. Even rows go into a single-port line store of
// MAX_WIDTH entries; each odd-row pixel reads the pixel above through a registered
// read, then the column butterfly and output registers carry the coefficient beat.
// The three stages (store read, column butterflies, output register) advance
// independently, so pixels keep flowing while a result waits in the output register;
// s_axis_tready drops only once all three stages hold work and m_axis_tready is low.
//
// Reset clears the counters, restores width and height to 512 (width to MAX_WIDTH if
// smaller) and empties the pipeline. The line store is not cleared; an entry is read
// only after the even row above has written it.
module integer_haar_2d_forward #(
	parameter int unsigned MAX_WIDTH = haar2d_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // pixel[7:0]
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// approx[7:0], hdetail[16:8], vdetail[25:17], diag[35:26], zero[39:36]
	output logic [haar2d_pkg::TDATA_BITS-1:0]   m_axis_tdata,
	output logic                                m_axis_tlast,  // frame_end
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [haar2d_pkg::DIM_BITS-1:0]     cfg_data
);
	import haar2d_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WIDTH);

	logic          step;
	pos_t          pos, pos_s1;
	logic [AW-1:0] addr;
	logic          valid_s1, adv;
	pixel_t        px_s1, rd_s1;
	coef_t         coef;

	assign s_axis_tready = !valid_s1 || adv;
	assign step          = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	haar2d_raster #(.MAX_WIDTH(MAX_WIDTH)) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.pos       (pos),
		.addr      (addr)
	);

	haar2d_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.pos      (pos),
		.addr     (addr),
		.px       (s_axis_tdata[PIXEL_BITS-1:0]),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.pos_s1   (pos_s1),
		.px_s1    (px_s1),
		.rd_s1    (rd_s1)
	);

	haar2d_butterfly u_bfly (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.pos_s1    (pos_s1),
		.px_s1     (px_s1),
		.rd_s1     (rd_s1),
		.out_ready (m_axis_tready),
		.adv       (adv),
		.out_valid (m_axis_tvalid),
		.coef      (coef)
	);

	assign m_axis_tdata = {4'b0000, coef.diag, coef.vdetail, coef.hdetail, coef.approx};
	assign m_axis_tlast = coef.frame_end;

endmodule

[sv/haar2d_checker.sv]
module haar2d_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [haar2d_pkg::TDATA_BITS-1:0] m_axis_tdata,
	input logic                              m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// a sink that takes every beat never stalls the pixel stream
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while the sink is ready");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid right after reset");

endmodule

bind integer_haar_2d_forward haar2d_checker u_haar2d_checker (.*);
